// ===== hdl/aumb_pkg.sv =====
// Package for the adaptive unsharp-mask blend core: widths, register indexes, reset values.
`timescale 1ns / 1ps

package aumb_pkg;

  // Field widths
  localparam int unsigned PixW    = 16;
  localparam int unsigned AmtW    = 16;
  localparam int unsigned InvW    = 33;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 33;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 16;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    RegAdaptiveMode    = 3'd0,
    RegAmountMin       = 3'd1,
    RegAmountMax       = 3'd2,
    RegThreshold       = 3'd3,
    RegTransitionWidth = 3'd4,
    RegInverseWidth    = 3'd5
  } cfg_reg_e;

  // Reset values
  localparam logic             AdaptiveModeRst    = 1'b0;
  localparam logic [AmtW-1:0]  AmountMinRst       = 16'd256;
  localparam logic [AmtW-1:0]  AmountMaxRst       = 16'd256;
  localparam logic [PixW-1:0]  ThresholdRst       = 16'd32768;
  localparam logic [PixW-1:0]  TransitionWidthRst = 16'd4096;
  localparam logic [InvW-1:0]  InverseWidthRst    = 33'd1048576;

  // Normalized curve: 1.0 in Q1.16
  localparam logic [16:0] TOne = 17'd65536;

  // Number of register stages in the datapath
  localparam int unsigned NumStages = 9;

endpackage

// ===== hdl/adaptive_unsharp_mask_blend_core.sv =====
// Adaptive unsharp-mask blend core: pipelined per-pixel sharpen with brightness-driven amount.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                   Payload
//  s_axis    in         s_axis_tvalid_i/tready_o    sharp, blurred, brightness pixels
//  m_axis    out        m_axis_tvalid_o/tready_i    sharpened pixel
//  cfg       in         cfg_we_i                    register index + write data
//
//  One pixel enters per clock, unless the output stalls, through nine register stages; each result
//  is valid on the output from the last register stage.
//  The depth is set by the chain of multipliers: offset times reciprocal, t squared, t cubed,
//  span times curve, and amount times detail, each followed by a register.
//  Reset clears the valid bits and loads the register defaults; no clearing pass is needed.
//  Each full stage holds when the stage after it is full and stalled, so a stall on the output
//  backs up stage by stage and bubbles are squeezed out.

module adaptive_unsharp_mask_blend_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [aumb_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [aumb_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Input stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [15:0] sharp_pixel, [31:16] blurred_pixel, [47:32] brightness_pixel
  input  logic [aumb_pkg::InDataW-1:0]   s_axis_tdata_i,
  // Output stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [15:0] out_pixel
  output logic [aumb_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  import aumb_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic             adaptive_mode_q;
  logic [AmtW-1:0]  amount_min_q;
  logic [AmtW-1:0]  amount_hi_q;
  logic [PixW-1:0]  threshold_q;
  logic [PixW-1:0]  width_q;
  logic [InvW-1:0]  inv_width_q;

  // Decode the write index; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adaptive_mode_q <= AdaptiveModeRst;
      amount_min_q    <= AmountMinRst;
      amount_hi_q     <= AmountMaxRst;
      threshold_q     <= ThresholdRst;
      width_q         <= TransitionWidthRst;
      inv_width_q     <= InverseWidthRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegAdaptiveMode:    adaptive_mode_q <= cfg_wdata_i[0];
        RegAmountMin:       amount_min_q    <= cfg_wdata_i[AmtW-1:0];
        RegAmountMax:       amount_hi_q     <= cfg_wdata_i[AmtW-1:0];
        RegThreshold:       threshold_q     <= cfg_wdata_i[PixW-1:0];
        RegTransitionWidth: width_q         <= cfg_wdata_i[PixW-1:0];
        RegInverseWidth:    inv_width_q     <= cfg_wdata_i[InvW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage flow control
  // ---------------------------------------------------------------------------
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;

  // Advance a stage when it is empty or the next stage advances
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || m_axis_tready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = vld_q[NumStages-1];

  // ---------------------------------------------------------------------------
  // Stage 0: unpack, region test, offset magnitude
  // ---------------------------------------------------------------------------
  logic [PixW-1:0] in_sharp, in_blur, in_bright;
  logic [PixW:0]   lum_plus_w, thr_plus_w;
  logic            below, above;
  logic [PixW:0]   off;
  logic            off_neg;
  logic [PixW-1:0] off_mag;

  assign in_sharp  = s_axis_tdata_i[15:0];
  assign in_blur   = s_axis_tdata_i[31:16];
  assign in_bright = s_axis_tdata_i[47:32];

  always_comb begin
    lum_plus_w = {1'b0, in_bright} + {1'b0, width_q};
    thr_plus_w = {1'b0, threshold_q} + {1'b0, width_q};
    below      = lum_plus_w < {1'b0, threshold_q};
    above      = {1'b0, in_bright} > thr_plus_w;
    off        = {1'b0, in_bright} - {1'b0, threshold_q};
    off_neg    = off[PixW];
    off_mag    = off_neg ? PixW'(-off) : off[PixW-1:0];
  end

  logic [PixW-1:0] s0_sharp_q, s0_blur_q, s0_mag_q;
  logic            s0_neg_q, s0_min_q, s0_max_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_sharp_q <= in_sharp;
      s0_blur_q  <= in_blur;
      s0_mag_q   <= off_mag;
      s0_neg_q   <= off_neg;
      // Fixed mode always takes the upper amount
      s0_min_q   <= adaptive_mode_q && below;
      s0_max_q   <= !adaptive_mode_q || above;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: offset times reciprocal width
  // ---------------------------------------------------------------------------
  logic [PixW+InvW-1:0] s1_prod_q;
  logic [PixW-1:0]      s1_sharp_q, s1_blur_q;
  logic                 s1_neg_q, s1_min_q, s1_max_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_prod_q  <= {{InvW{1'b0}}, s0_mag_q} * {{PixW{1'b0}}, inv_width_q};
      s1_sharp_q <= s0_sharp_q;
      s1_blur_q  <= s0_blur_q;
      s1_neg_q   <= s0_neg_q;
      s1_min_q   <= s0_min_q;
      s1_max_q   <= s0_max_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: round and saturate |t|, square it
  // ---------------------------------------------------------------------------
  logic [PixW+InvW:0] t_round;
  logic [16:0]        t_mag;

  always_comb begin
    t_round = {1'b0, s1_prod_q} + (PixW+InvW+1)'(32768);
    t_mag   = (t_round[PixW+InvW:16] > {17'd0, TOne}) ? TOne : t_round[32:16];
  end

  logic [16:0]     s2_t_q;
  logic [33:0]     s2_t2_q;
  logic [PixW-1:0] s2_sharp_q, s2_blur_q;
  logic            s2_neg_q, s2_min_q, s2_max_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_t_q     <= t_mag;
      s2_t2_q    <= {17'd0, t_mag} * {17'd0, t_mag};
      s2_sharp_q <= s1_sharp_q;
      s2_blur_q  <= s1_blur_q;
      s2_neg_q   <= s1_neg_q;
      s2_min_q   <= s1_min_q;
      s2_max_q   <= s1_max_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: cube
  // ---------------------------------------------------------------------------
  logic [50:0]     s3_t3_q;
  logic [16:0]     s3_t_q;
  logic [PixW-1:0] s3_sharp_q, s3_blur_q;
  logic            s3_neg_q, s3_min_q, s3_max_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_t3_q    <= {17'd0, s2_t2_q} * {34'd0, s2_t_q};
      s3_t_q     <= s2_t_q;
      s3_sharp_q <= s2_sharp_q;
      s3_blur_q  <= s2_blur_q;
      s3_neg_q   <= s2_neg_q;
      s3_min_q   <= s2_min_q;
      s3_max_q   <= s2_max_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: curve g = 3|t| - |t|^3, range 0..2.0 in Q.16
  // ---------------------------------------------------------------------------
  logic [51:0] t3_round;
  logic [18:0] t3_q16;
  logic [18:0] g_full;

  always_comb begin
    t3_round = {1'b0, s3_t3_q} + 52'h0_0000_8000_0000;
    t3_q16   = t3_round[50:32];
    g_full   = ({2'b00, s3_t_q} + {1'b0, s3_t_q, 1'b0}) - t3_q16;
  end

  logic [17:0]     s4_g_q;
  logic [PixW-1:0] s4_sharp_q, s4_blur_q;
  logic            s4_neg_q, s4_min_q, s4_max_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_g_q     <= g_full[17:0];
      s4_sharp_q <= s3_sharp_q;
      s4_blur_q  <= s3_blur_q;
      s4_neg_q   <= s3_neg_q;
      s4_min_q   <= s3_min_q;
      s4_max_q   <= s3_max_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: amount span times curve
  // ---------------------------------------------------------------------------
  logic signed [AmtW:0] span;

  assign span = $signed({1'b0, amount_hi_q}) - $signed({1'b0, amount_min_q});

  logic signed [35:0] s5_dg_q;
  logic [PixW-1:0]    s5_sharp_q, s5_blur_q;
  logic               s5_neg_q, s5_min_q, s5_max_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_dg_q    <= 36'(span) * 36'($signed({1'b0, s4_g_q}));
      s5_sharp_q <= s4_sharp_q;
      s5_blur_q  <= s4_blur_q;
      s5_neg_q   <= s4_neg_q;
      s5_min_q   <= s4_min_q;
      s5_max_q   <= s4_max_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: amount = round(mid + s * span * g / 4), then region select
  // ---------------------------------------------------------------------------
  logic signed [37:0] base, num;
  logic [37:0]        num_round;
  logic [AmtW-1:0]    amt_curve, amt_sel;

  always_comb begin
    base      = $signed({4'b0000, {1'b0, amount_min_q} + {1'b0, amount_hi_q}, 17'd0});
    num       = s5_neg_q ? (base - 38'(s5_dg_q)) : (base + 38'(s5_dg_q));
    num_round = (num < 0) ? 38'd131072 : (38'(unsigned'(num)) + 38'd131072);
    amt_curve = num_round[33:18];
    if (s5_min_q) begin
      amt_sel = amount_min_q;
    end else if (s5_max_q) begin
      amt_sel = amount_hi_q;
    end else begin
      amt_sel = amt_curve;
    end
  end

  logic [AmtW-1:0] s6_amt_q;
  logic [PixW-1:0] s6_sharp_q, s6_blur_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_amt_q   <= amt_sel;
      s6_sharp_q <= s5_sharp_q;
      s6_blur_q  <= s5_blur_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: amount times detail
  // ---------------------------------------------------------------------------
  logic signed [PixW:0] detail;

  assign detail = $signed({1'b0, s6_sharp_q}) - $signed({1'b0, s6_blur_q});

  logic signed [33:0] s7_prod_q;
  logic [PixW-1:0]    s7_blur_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s7_prod_q <= 34'($signed({1'b0, s6_amt_q})) * 34'(detail);
      s7_blur_q <= s6_blur_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: blend, round and saturate into the output register
  // ---------------------------------------------------------------------------
  logic signed [35:0] blend;
  logic [PixW-1:0]    pix_sat;

  always_comb begin
    blend = $signed({12'd0, s7_blur_q, 8'd0}) + 36'(s7_prod_q) + 36'sd128;
    if (blend < 0) begin
      pix_sat = '0;
    end else if (blend[35:24] != 12'd0) begin
      pix_sat = '1;
    end else begin
      pix_sat = blend[23:8];
    end
  end

  logic [PixW-1:0] s8_pix_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s8_pix_q <= pix_sat;
    end
  end

  assign m_axis_tdata_o = s8_pix_q;

endmodule
